[rtl/rtfu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package rtfu_pkg;

	// Instruction codes
	typedef enum logic [4:0] {
		KIND_NOP = 5'd0,
		KIND_XBA = 5'd1,
		KIND_XCE = 5'd2,
		KIND_CLC = 5'd3,
		KIND_SEC = 5'd4,
		KIND_CLI = 5'd5,
		KIND_SEI = 5'd6,
		KIND_CLV = 5'd7,
		KIND_CLD = 5'd8,
		KIND_SED = 5'd9,
		KIND_REP = 5'd10,
		KIND_SEP = 5'd11,
		KIND_TSC = 5'd12,
		KIND_TCD = 5'd13,
		KIND_TDC = 5'd14,
		KIND_TXA = 5'd15,
		KIND_TYA = 5'd16,
		KIND_TXY = 5'd17,
		KIND_TAY = 5'd18,
		KIND_TAX = 5'd19,
		KIND_TYX = 5'd20,
		KIND_TCS = 5'd21,
		KIND_TSX = 5'd22,
		KIND_TXS = 5'd23
	} kind_t;

	// Status bits, NVMXDIZC
	localparam logic [7:0] FLAG_N  = 8'h80;
	localparam logic [7:0] FLAG_V  = 8'h40;
	localparam logic [7:0] FLAG_MX = 8'h30;
	localparam logic [7:0] FLAG_X  = 8'h10;
	localparam logic [7:0] FLAG_D  = 8'h08;
	localparam logic [7:0] FLAG_I  = 8'h04;
	localparam logic [7:0] FLAG_Z  = 8'h02;
	localparam logic [7:0] FLAG_C  = 8'h01;

	localparam logic [7:0] STACK_PAGE_EMU = 8'h01;

	// Programmer-visible register set
	typedef struct packed {
		logic [15:0] acc;
		logic [15:0] idx_x;
		logic [15:0] idx_y;
		logic [15:0] stk;
		logic [15:0] dir;
		logic [7:0]  p;
		logic        e;
	} regs_t;

	localparam regs_t REGS_RESET = '{
		acc:   16'h0000,
		idx_x: 16'h0000,
		idx_y: 16'h0000,
		stk:   16'h01FF,
		dir:   16'h0000,
		p:     8'h34,
		e:     1'b1
	};

endpackage

`default_nettype wire

[rtl/rtfu_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rtfu_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] kind;
	logic       word_size;
	logic [7:0] imm_mask;

	modport source (output valid, output kind, output word_size, output imm_mask,
		input ready);
	modport sink (input valid, input kind, input word_size, input imm_mask,
		output ready);
endinterface

`default_nettype wire

[rtl/rtfu_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface rtfu_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] acc_out;
	logic [15:0] index_x_out;
	logic [15:0] index_y_out;
	logic [15:0] stack_out;
	logic [15:0] direct_out;
	logic [7:0]  status_out;
	logic        emulation_out;

	modport source (output valid, output acc_out, output index_x_out, output index_y_out,
		output stack_out, output direct_out, output status_out, output emulation_out,
		input ready);
	modport sink (input valid, input acc_out, input index_x_out, input index_y_out,
		input stack_out, input direct_out, input status_out, input emulation_out,
		output ready);
endinterface

`default_nettype wire

[rtl/rtfu_exec.sv]
`timescale 1ns / 1ps
`default_nettype none

module rtfu_exec import rtfu_pkg::*; (
	input  regs_t      cur,
	input  logic [4:0] kind,
	input  logic       word_size,
	input  logic [7:0] imm_mask,
	output regs_t      nxt
);

	// Replace N and Z from an 8-bit value
	function automatic logic [7:0] nz8(input logic [7:0] p, input logic [15:0] v);
		logic [7:0] r;
		r = p & ~(FLAG_N | FLAG_Z);
		if (v[7]) r = r | FLAG_N;
		if (v[7:0] == 8'h00) r = r | FLAG_Z;
		return r;
	endfunction

	// Replace N and Z from a 16-bit value
	function automatic logic [7:0] nz16(input logic [7:0] p, input logic [15:0] v);
		logic [7:0] r;
		r = p & ~(FLAG_N | FLAG_Z);
		if (v[15]) r = r | FLAG_N;
		if (v == 16'h0000) r = r | FLAG_Z;
		return r;
	endfunction

	logic [15:0] src;
	logic [15:0] dst;
	logic [15:0] moved;
	logic [7:0]  moved_p;
	logic [15:0] stk_src;
	logic [15:0] stk_new;

	// Pick the operands of a sized transfer
	always_comb begin
		src = cur.idx_x;
		dst = cur.acc;
		case (kind_t'(kind))
			KIND_TXA: begin src = cur.idx_x; dst = cur.acc;   end
			KIND_TYA: begin src = cur.idx_y; dst = cur.acc;   end
			KIND_TXY: begin src = cur.idx_x; dst = cur.idx_y; end
			KIND_TAY: begin src = cur.acc;   dst = cur.idx_y; end
			KIND_TAX: begin src = cur.acc;   dst = cur.idx_x; end
			KIND_TYX: begin src = cur.idx_y; dst = cur.idx_x; end
			KIND_TSX: begin src = cur.stk;   dst = cur.idx_x; end
			default:  begin src = cur.idx_x; dst = cur.acc;   end
		endcase
	end

	// Sized move: byte keeps the destination high byte
	always_comb begin
		if (word_size) begin
			moved   = src;
			moved_p = nz16(cur.p, src);
		end else begin
			moved   = {dst[15:8], src[7:0]};
			moved_p = nz8(cur.p, src);
		end
	end

	// Transfer into S keeps page one in emulation
	assign stk_src = (kind_t'(kind) == KIND_TXS) ? cur.idx_x : cur.acc;
	assign stk_new = cur.e ? {cur.stk[15:8], stk_src[7:0]} : stk_src;

	// Execute one instruction
	always_comb begin
		nxt = cur;
		case (kind_t'(kind))
			KIND_XBA: begin
				nxt.acc = {cur.acc[7:0], cur.acc[15:8]};
				nxt.p   = nz8(cur.p, {8'h00, cur.acc[15:8]});
			end
			KIND_XCE: begin
				nxt.e = cur.p[0];
				nxt.p = (cur.p & ~FLAG_C) | {7'd0, cur.e};
				if (cur.p[0]) begin
					nxt.p   = nxt.p | FLAG_MX;
					nxt.stk = {STACK_PAGE_EMU, cur.stk[7:0]};
				end
				if ((nxt.p & FLAG_X) != 8'h00) begin
					nxt.idx_x = {8'h00, cur.idx_x[7:0]};
					nxt.idx_y = {8'h00, cur.idx_y[7:0]};
				end
			end
			KIND_CLC: nxt.p = cur.p & ~FLAG_C;
			KIND_SEC: nxt.p = cur.p | FLAG_C;
			KIND_CLI: nxt.p = cur.p & ~FLAG_I;
			KIND_SEI: nxt.p = cur.p | FLAG_I;
			KIND_CLV: nxt.p = cur.p & ~FLAG_V;
			KIND_CLD: nxt.p = cur.p & ~FLAG_D;
			KIND_SED: nxt.p = cur.p | FLAG_D;
			KIND_REP, KIND_SEP: begin
				if (kind_t'(kind) == KIND_REP) nxt.p = cur.p & ~imm_mask;
				else nxt.p = cur.p | imm_mask;
				if (cur.e) nxt.p = nxt.p | FLAG_MX;
				if ((nxt.p & FLAG_X) != 8'h00) begin
					nxt.idx_x = {8'h00, cur.idx_x[7:0]};
					nxt.idx_y = {8'h00, cur.idx_y[7:0]};
				end
			end
			KIND_TSC: begin
				nxt.acc = cur.stk;
				nxt.p   = nz16(cur.p, cur.stk);
			end
			KIND_TCD: begin
				nxt.dir = cur.acc;
				nxt.p   = nz16(cur.p, cur.acc);
			end
			KIND_TDC: begin
				nxt.acc = cur.dir;
				nxt.p   = nz16(cur.p, cur.dir);
			end
			KIND_TXA, KIND_TYA: begin
				nxt.acc = moved;
				nxt.p   = moved_p;
			end
			KIND_TXY, KIND_TAY: begin
				nxt.idx_y = moved;
				nxt.p     = moved_p;
			end
			KIND_TAX, KIND_TYX, KIND_TSX: begin
				nxt.idx_x = moved;
				nxt.p     = moved_p;
			end
			KIND_TCS, KIND_TXS: nxt.stk = stk_new;
			default: nxt = cur;
		endcase
	end

endmodule

`default_nettype wire

[rtl/cpu_register_transfer_flag_unit_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Register transfer and flag unit of a 16-bit 6502-family CPU.
// Channel in_ch carries one register-only instruction per transfer (kind,
// word_size, imm_mask). Channel out_ch returns, for every instruction, the
// full register set after it: A, X, Y, S, D, the status byte and E.
// Both channels transfer on a rising edge with valid and ready high.
// The instruction executes while it sits in the input register, and the
// execute logic writes the register file and the result register together;
// out_ch.valid rises when the result register loads.
// Throughput: one instruction per cycle while out_ch does not stall, set by
// the single register-file update path; a new instruction is taken while a
// result waits.
// When out_ch stalls, the result register holds, the input register holds
// one more instruction, and in_ch.ready drops once both are full.
// Reset (arst_n low) empties both stages and loads the hardware reset
// values: A, X, Y, D zero, S 0x01FF, status 0x34, emulation mode on.

module cpu_register_transfer_flag_unit_core import rtfu_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	rtfu_in_if.sink     in_ch,
	rtfu_out_if.source  out_ch
);

	logic       valid_s1;
	logic [4:0] kind_s1;
	logic       word_size_s1;
	logic [7:0] imm_mask_s1;
	logic       valid_s2;
	regs_t      res_s2;
	regs_t      regs_q;
	regs_t      regs_nxt;
	logic       ld_s2;
	logic       adv_s1;
	logic       take_in;

	// Handshake: result stage frees when empty or being taken
	assign ld_s2    = !valid_s2 || out_ch.ready;
	assign adv_s1   = valid_s1 && ld_s2;
	assign in_ch.ready = !valid_s1 || ld_s2;
	assign take_in  = in_ch.valid && in_ch.ready;

	// Hold the instruction in the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			kind_s1      <= in_ch.kind;
			word_size_s1 <= in_ch.word_size;
			imm_mask_s1  <= in_ch.imm_mask;
		end
	end

	rtfu_exec u_exec (
		.cur       (regs_q),
		.kind      (kind_s1),
		.word_size (word_size_s1),
		.imm_mask  (imm_mask_s1),
		.nxt       (regs_nxt)
	);

	// Advance the register file on execution
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q   <= REGS_RESET;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) regs_q <= regs_nxt;
			if (ld_s2) valid_s2 <= valid_s1;
		end
	end

	// Capture the result
	always_ff @(posedge clk) begin
		if (adv_s1) res_s2 <= regs_nxt;
	end

	assign out_ch.valid         = valid_s2;
	assign out_ch.acc_out       = res_s2.acc;
	assign out_ch.index_x_out   = res_s2.idx_x;
	assign out_ch.index_y_out   = res_s2.idx_y;
	assign out_ch.stack_out     = res_s2.stk;
	assign out_ch.direct_out    = res_s2.dir;
	assign out_ch.status_out    = res_s2.p;
	assign out_ch.emulation_out = res_s2.e;

	// Emulation mode keeps M, X set and the stack in page one
	a_emu_invariant: assert property (@(posedge clk) disable iff (!arst_n)
		regs_q.e |-> ((regs_q.p & FLAG_MX) == FLAG_MX && regs_q.stk[15:8] == STACK_PAGE_EMU))
		else $error("emulation invariant broken");

	// Registers change only when an instruction executes
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s1 |=> $stable(regs_q))
		else $error("register file changed without an instruction");

	// An executed instruction shows up as a result
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> (valid_s2 && res_s2 == regs_q))
		else $error("result does not match register file");

	// A pending result blocks execution until taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ch.ready) |-> !adv_s1)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

[sim/tb_cpu_register_transfer_flag_unit_core.sv]
`timescale 1ns / 1ps

module tb_cpu_register_transfer_flag_unit_core;
	import rtfu_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 8;

	// Register-set predictor and result checker
	class regfile_scoreboard;
		regs_t cur;
		regs_t pending_q[$];
		int errors;

		function new();
			cur = REGS_RESET;
			errors = 0;
		endfunction

		function logic [7:0] nz_byte(logic [7:0] p, logic [15:0] v);
			logic [7:0] r;
			r = p & ~(FLAG_N | FLAG_Z);
			if (v[7]) r = r | FLAG_N;
			if (v[7:0] == 8'h00) r = r | FLAG_Z;
			return r;
		endfunction

		function logic [7:0] nz_word(logic [7:0] p, logic [15:0] v);
			logic [7:0] r;
			r = p & ~(FLAG_N | FLAG_Z);
			if (v[15]) r = r | FLAG_N;
			if (v == 16'h0000) r = r | FLAG_Z;
			return r;
		endfunction

		// Byte transfer keeps the destination high byte; word transfer moves all
		function logic [15:0] sized_move(logic [15:0] src, logic [15:0] dst, bit wide,
				inout logic [7:0] p);
			if (wide) begin
				p = nz_word(p, src);
				return src;
			end
			p = nz_byte(p, src);
			return {dst[15:8], src[7:0]};
		endfunction

		function logic [15:0] stack_load(logic [15:0] src);
			if (cur.e) return {cur.stk[15:8], src[7:0]};
			return src;
		endfunction

		function void trim_index();
			if ((cur.p & FLAG_X) != 8'h00) begin
				cur.idx_x[15:8] = 8'h00;
				cur.idx_y[15:8] = 8'h00;
			end
		endfunction

		function void force_emu_mx();
			if (cur.e) cur.p = cur.p | FLAG_MX;
		endfunction

		// Advance the predicted registers by one accepted instruction
		function void note_input(logic [4:0] kind, bit wide, logic [7:0] mask);
			logic carry;
			logic [7:0] p;
			p = cur.p;
			case (kind)
				KIND_XBA: begin
					cur.acc = {cur.acc[7:0], cur.acc[15:8]};
					cur.p = nz_byte(cur.p, cur.acc);
				end
				KIND_XCE: begin
					carry = cur.p[0];
					cur.p = (cur.p & ~FLAG_C) | {7'b0, cur.e};
					cur.e = carry;
					if (cur.e) begin
						cur.p = cur.p | FLAG_MX;
						cur.stk = {STACK_PAGE_EMU, cur.stk[7:0]};
					end
					trim_index();
				end
				KIND_CLC: cur.p = cur.p & ~FLAG_C;
				KIND_SEC: cur.p = cur.p | FLAG_C;
				KIND_CLI: cur.p = cur.p & ~FLAG_I;
				KIND_SEI: cur.p = cur.p | FLAG_I;
				KIND_CLV: cur.p = cur.p & ~FLAG_V;
				KIND_CLD: cur.p = cur.p & ~FLAG_D;
				KIND_SED: cur.p = cur.p | FLAG_D;
				KIND_REP: begin
					cur.p = cur.p & ~mask;
					force_emu_mx();
					trim_index();
				end
				KIND_SEP: begin
					cur.p = cur.p | mask;
					force_emu_mx();
					trim_index();
				end
				KIND_TSC: begin
					cur.acc = cur.stk;
					cur.p = nz_word(cur.p, cur.acc);
				end
				KIND_TCD: begin
					cur.dir = cur.acc;
					cur.p = nz_word(cur.p, cur.dir);
				end
				KIND_TDC: begin
					cur.acc = cur.dir;
					cur.p = nz_word(cur.p, cur.acc);
				end
				KIND_TXA: begin
					cur.acc = sized_move(cur.idx_x, cur.acc, wide, p);
					cur.p = p;
				end
				KIND_TYA: begin
					cur.acc = sized_move(cur.idx_y, cur.acc, wide, p);
					cur.p = p;
				end
				KIND_TXY: begin
					cur.idx_y = sized_move(cur.idx_x, cur.idx_y, wide, p);
					cur.p = p;
				end
				KIND_TAY: begin
					cur.idx_y = sized_move(cur.acc, cur.idx_y, wide, p);
					cur.p = p;
				end
				KIND_TAX: begin
					cur.idx_x = sized_move(cur.acc, cur.idx_x, wide, p);
					cur.p = p;
				end
				KIND_TYX: begin
					cur.idx_x = sized_move(cur.idx_y, cur.idx_x, wide, p);
					cur.p = p;
				end
				KIND_TCS: cur.stk = stack_load(cur.acc);
				KIND_TSX: begin
					cur.idx_x = sized_move(cur.stk, cur.idx_x, wide, p);
					cur.p = p;
				end
				KIND_TXS: cur.stk = stack_load(cur.idx_x);
				default: ;
			endcase
			pending_q.push_back(cur);
		endfunction

		task report_mismatch(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		task check_field(string name, logic [15:0] got, logic [15:0] want);
			if (got !== want)
				report_mismatch($sformatf("%s got %h expected %h", name, got, want));
		endtask

		// Compare one transferred result with the oldest prediction
		task check_result(regs_t got);
			regs_t want;
			if (pending_q.size() == 0) begin
				report_mismatch("result with no instruction outstanding");
				return;
			end
			want = pending_q.pop_front();
			check_field("acc", got.acc, want.acc);
			check_field("x", got.idx_x, want.idx_x);
			check_field("y", got.idx_y, want.idx_y);
			check_field("s", got.stk, want.stk);
			check_field("d", got.dir, want.dir);
			check_field("p", {8'h00, got.p}, {8'h00, want.p});
			check_field("e", {15'h0, got.e}, {15'h0, want.e});
		endtask
	endclass

	logic clk;
	logic arst_n;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	regfile_scoreboard sb;

	rtfu_in_if in_ch ();
	rtfu_out_if out_ch ();

	cpu_register_transfer_flag_unit_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Randomly stall the result channel
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result('{acc: out_ch.acc_out, idx_x: out_ch.index_x_out,
				idx_y: out_ch.index_y_out, stk: out_ch.stack_out, dir: out_ch.direct_out,
				p: out_ch.status_out, e: out_ch.emulation_out});
	end

	// Abort when neither channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Present one instruction and hold it until the transfer; enter and leave at negedge
	task drive_item(logic [4:0] kind, bit wide, logic [7:0] mask);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= kind;
		in_ch.word_size <= wide;
		in_ch.imm_mask <= mask;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_input(kind, wide, mask);
		@(negedge clk);
	endtask

	// Hold off the sender until every predicted result has arrived
	task wait_all_results();
		in_ch.valid <= 1'b0;
		while (sb.pending_q.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task drive_random(int count);
		int sent;
		int roll;
		logic [4:0] kind;
		sent = 0;
		while (sent < count) begin
			roll = $urandom_range(99);
			if (roll < 8) begin
				// mode switch: set or clear carry, then exchange with E
				drive_item($urandom_range(1) ? KIND_SEC : KIND_CLC, 1'($urandom), 8'($urandom));
				drive_item(KIND_XCE, 1'($urandom), 8'($urandom));
				sent += 2;
			end else if (roll < 16) begin
				kind = $urandom_range(1) ? KIND_REP : KIND_SEP;
				drive_item(kind, 1'($urandom),
					$urandom_range(1) ? FLAG_X : ($urandom_range(1) ? FLAG_MX : 8'($urandom)));
				sent++;
			end else if (roll < 21) begin
				// unused codes behave as nop and do not count
				drive_item(5'($urandom_range(31, 24)), 1'($urandom), 8'($urandom));
			end else begin
				drive_item(5'($urandom_range(23)), 1'($urandom), 8'($urandom));
				sent++;
			end
		end
	endtask

	initial begin
		sb = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_NOP;
		in_ch.word_size = 1'b0;
		in_ch.imm_mask = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: emulation after reset, then native, then back
		drive_item(KIND_NOP, 1'b1, 8'hFF);
		drive_item(5'd31, 1'b0, 8'h00);
		drive_item(KIND_TSC, 1'b0, 8'h00);
		drive_item(KIND_XBA, 1'b0, 8'h00);
		drive_item(KIND_REP, 1'b0, 8'hFF);
		drive_item(KIND_TAX, 1'b1, 8'h00);
		drive_item(KIND_SEC, 1'b0, 8'h00);
		drive_item(KIND_XCE, 1'b0, 8'h00);
		drive_item(KIND_CLC, 1'b0, 8'h00);
		drive_item(KIND_XCE, 1'b0, 8'h00);
		drive_item(KIND_REP, 1'b0, 8'hFF);
		drive_item(KIND_TAY, 1'b0, 8'h00);
		drive_item(KIND_TAX, 1'b1, 8'h00);
		drive_item(KIND_TXY, 1'b1, 8'h00);
		drive_item(KIND_SEP, 1'b0, FLAG_X);
		drive_item(KIND_TYX, 1'b1, 8'h00);
		drive_item(KIND_TXA, 1'b0, 8'h00);
		drive_item(KIND_TYA, 1'b1, 8'h00);
		drive_item(KIND_TCD, 1'b0, 8'h00);
		drive_item(KIND_TDC, 1'b0, 8'h00);
		drive_item(KIND_XBA, 1'b0, 8'h00);
		drive_item(KIND_TCS, 1'b0, 8'h00);
		drive_item(KIND_TSX, 1'b0, 8'h00);
		drive_item(KIND_TXS, 1'b0, 8'h00);
		drive_item(KIND_SEP, 1'b1, 8'hFF);
		drive_item(KIND_CLI, 1'b0, 8'h00);
		drive_item(KIND_CLV, 1'b0, 8'h00);
		drive_item(KIND_CLD, 1'b0, 8'h00);
		drive_item(KIND_SEI, 1'b0, 8'h00);
		drive_item(KIND_SED, 1'b0, 8'h00);
		drive_item(KIND_XCE, 1'b0, 8'h00);
		drive_item(KIND_REP, 1'b1, 8'hFF);
		drive_item(KIND_TCS, 1'b1, 8'h00);
		wait_all_results();

		// Random phases with different flow-control pressure
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drive_random(450);
		wait_all_results();
		send_idle_pct = 87;
		recv_stall_pct = 0;
		drive_random(450);
		wait_all_results();
		send_idle_pct = 0;
		recv_stall_pct = 87;
		drive_random(450);
		wait_all_results();
		send_idle_pct = 12;
		recv_stall_pct = 12;
		drive_random(450);
		wait_all_results();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
